[rtl/dtid_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtid_pkg - shared types and constants
// Register codes, reset values and result packing for the dual threshold
// interval detector.
// ----------------------------------------------------------------------------
package dtid_pkg;

	// Configuration register codes
	localparam int CFG_IDX_W = 4;
	localparam logic [CFG_IDX_W-1:0] REG_THR_LOW_CH1  = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_THR_HIGH_CH2 = 4'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_INTERVAL = 4'd2;
	localparam logic [CFG_IDX_W-1:0] REG_BYPASS_MIN   = 4'd3;

	// Reset values: thresholds are -0.5 and +0.5 in Q4.12
	localparam int THR_LOW_RST  = -2048;
	localparam int THR_HIGH_RST = 2048;
	localparam int THR_RST_W    = 13;   // signed bits that hold both reset values
	localparam int LEN_W        = 16;
	localparam logic [LEN_W-1:0] MIN_INTERVAL_RST = 16'd10;

	// Result packing
	localparam int OUT_IDX_W   = 32;
	localparam int OUT_FIELD_W = 2 * (1 + 2 * OUT_IDX_W);
	localparam int OUT_W       = ((OUT_FIELD_W + 7) / 8) * 8;

	typedef struct packed {
		logic [LEN_W-1:0] min_interval;
		logic             bypass;
	} dtid_len_cfg_t;

endpackage

[rtl/dtid_cfg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtid_cfg - configuration registers
// Holds both thresholds, the minimum interval length and the bypass bit.
// ----------------------------------------------------------------------------
module dtid_cfg #(
	parameter int SAMPLE_BITS = 16
) (
	input  logic                                         clk,
	input  logic                                         arst_n,
	input  logic                                         cfg_we,
	input  logic [dtid_pkg::CFG_IDX_W-1:0]               cfg_index,
	input  logic [((SAMPLE_BITS > dtid_pkg::LEN_W) ? SAMPLE_BITS
	             : dtid_pkg::LEN_W)-1:0]                 cfg_data,
	output logic signed [((SAMPLE_BITS > dtid_pkg::THR_RST_W) ? SAMPLE_BITS
	             : dtid_pkg::THR_RST_W)-1:0]             thr_low,
	output logic signed [((SAMPLE_BITS > dtid_pkg::THR_RST_W) ? SAMPLE_BITS
	             : dtid_pkg::THR_RST_W)-1:0]             thr_high,
	output dtid_pkg::dtid_len_cfg_t                      len_cfg
);
	import dtid_pkg::*;

	localparam int THR_W = (SAMPLE_BITS > THR_RST_W) ? SAMPLE_BITS : THR_RST_W;

	logic signed [THR_W-1:0] wr_thr;

	// Sign-extend the written threshold from the sample width
	assign wr_thr = THR_W'(signed'(cfg_data[SAMPLE_BITS-1:0]));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_low              <= THR_W'(THR_LOW_RST);
			thr_high             <= THR_W'(THR_HIGH_RST);
			len_cfg.min_interval <= MIN_INTERVAL_RST;
			len_cfg.bypass       <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_THR_LOW_CH1:  thr_low              <= wr_thr;
				REG_THR_HIGH_CH2: thr_high             <= wr_thr;
				REG_MIN_INTERVAL: len_cfg.min_interval <= cfg_data[LEN_W-1:0];
				REG_BYPASS_MIN:   len_cfg.bypass       <= cfg_data[0];
				default: ;
			endcase
		end
	end

endmodule

[rtl/dtid_chan.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtid_chan - per-channel activity tracker
// Latches the start index on entry, closes the interval on exit and applies
// the minimum length check.
// ----------------------------------------------------------------------------
module dtid_chan #(
	parameter int INDEX_BITS = 32
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    adv,
	input  logic                    hit,
	input  logic [INDEX_BITS-1:0]   index,
	input  dtid_pkg::dtid_len_cfg_t len_cfg,
	output logic                    report,
	output logic [INDEX_BITS-1:0]   start
);
	import dtid_pkg::*;

	localparam int CMP_W = (INDEX_BITS > LEN_W) ? INDEX_BITS : LEN_W;

	logic                  active_q;
	logic [INDEX_BITS-1:0] start_q;
	logic [INDEX_BITS-1:0] len;
	logic                  long_enough;

	// Length wraps with the index counter
	assign len         = index - start_q;
	assign long_enough = CMP_W'(len) >= CMP_W'(len_cfg.min_interval);
	assign report      = adv && active_q && !hit && (len_cfg.bypass || long_enough);
	assign start       = start_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			start_q  <= '0;
		end else if (adv) begin
			if (hit && !active_q) begin
				active_q <= 1'b1;
				start_q  <= index;
			end else if (!hit && active_q) begin
				active_q <= 1'b0;
			end
		end
	end

endmodule

[rtl/dual_threshold_interval_detector.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dual_threshold_interval_detector - two-channel threshold interval detector
// Tracks runs of samples below (channel one) or above (channel two) a
// threshold and reports each finished run that meets the minimum length.
// ----------------------------------------------------------------------------
// Channel   Dir  Content
// s_axis    in   one sample pair per transaction
// m_axis    out  one interval report per transaction (either channel or both)
// cfg       in   register write, index 0..3, no read-back
//
// An accepted sample pair is held in the input stage, then both channel
// trackers and the index counter update in the same cycle, and any report
// lands in the output register: one transaction per clock sustained while
// m_tready is high. The output register frees the input stage whenever it
// is empty or being drained, so a held report does not stop samples that
// close no interval while m_tready is high. arst_n clears the counter,
// channel state, registers to their reset values and both valid flags.
// ----------------------------------------------------------------------------
module dual_threshold_interval_detector #(
	parameter int INDEX_BITS  = 32,
	parameter int SAMPLE_BITS = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// Sample stream; s_tdata: sample_ch1, sample_ch2, zero pad
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	input  logic [((2*SAMPLE_BITS+7)/8)*8-1:0]   s_tdata,
	// Report stream; m_tdata: ch1_valid, ch1_start, ch1_end,
	//                         ch2_valid, ch2_start, ch2_end, zero pad
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	output logic [dtid_pkg::OUT_W-1:0]           m_tdata,
	// Configuration write port
	input  logic                                 cfg_we,
	input  logic [dtid_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [((SAMPLE_BITS > dtid_pkg::LEN_W) ? SAMPLE_BITS
	             : dtid_pkg::LEN_W)-1:0]         cfg_data
);
	import dtid_pkg::*;

	localparam int THR_W = (SAMPLE_BITS > THR_RST_W) ? SAMPLE_BITS : THR_RST_W;
	localparam int EXT_W = (INDEX_BITS > OUT_IDX_W) ? INDEX_BITS : OUT_IDX_W;

	// Configuration
	logic signed [THR_W-1:0] thr_low;
	logic signed [THR_W-1:0] thr_high;
	dtid_len_cfg_t           len_cfg;

	// Input stage
	logic                          valid_s1;
	logic signed [SAMPLE_BITS-1:0] smp1_s1;
	logic signed [SAMPLE_BITS-1:0] smp2_s1;
	logic                          adv_s1;

	// Running index and channel results
	logic [INDEX_BITS-1:0] index_q;
	logic                  hit1;
	logic                  hit2;
	logic                  rep1;
	logic                  rep2;
	logic [INDEX_BITS-1:0] start1;
	logic [INDEX_BITS-1:0] start2;
	logic [EXT_W-1:0]      start1_ext;
	logic [EXT_W-1:0]      start2_ext;
	logic [EXT_W-1:0]      index_ext;

	// Output register
	logic                 m_tvalid_q;
	logic                 ch1_valid_q;
	logic [OUT_IDX_W-1:0] ch1_start_q;
	logic [OUT_IDX_W-1:0] ch1_end_q;
	logic                 ch2_valid_q;
	logic [OUT_IDX_W-1:0] ch2_start_q;
	logic [OUT_IDX_W-1:0] ch2_end_q;

	dtid_cfg #(
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.thr_low   (thr_low),
		.thr_high  (thr_high),
		.len_cfg   (len_cfg)
	);

	// Advance the input stage when the output register can take a report
	assign adv_s1   = valid_s1 && (!m_tvalid_q || m_tready);
	assign s_tready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	// Hold the sample pair; no reset needed on payload
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			smp1_s1 <= s_tdata[SAMPLE_BITS-1:0];
			smp2_s1 <= s_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
		end
	end

	// Threshold compares, both signed at the threshold width
	assign hit1 = THR_W'(smp1_s1) < thr_low;
	assign hit2 = THR_W'(smp2_s1) > thr_high;

	// Index of the sample in the input stage; wraps at INDEX_BITS
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			index_q <= '0;
		end else if (adv_s1) begin
			index_q <= index_q + INDEX_BITS'(1);
		end
	end

	dtid_chan #(
		.INDEX_BITS (INDEX_BITS)
	) u_chan1 (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv_s1),
		.hit     (hit1),
		.index   (index_q),
		.len_cfg (len_cfg),
		.report  (rep1),
		.start   (start1)
	);

	dtid_chan #(
		.INDEX_BITS (INDEX_BITS)
	) u_chan2 (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv_s1),
		.hit     (hit2),
		.index   (index_q),
		.len_cfg (len_cfg),
		.report  (rep2),
		.start   (start2)
	);

	// Indices go out in their low 32 bits, zero-extended when narrower
	assign start1_ext = EXT_W'(start1);
	assign start2_ext = EXT_W'(start2);
	assign index_ext  = EXT_W'(index_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (adv_s1 && (rep1 || rep2)) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	// Load the report; a silent channel reads as all zeros
	always_ff @(posedge clk) begin
		if (adv_s1 && (rep1 || rep2)) begin
			ch1_valid_q <= rep1;
			ch1_start_q <= rep1 ? start1_ext[OUT_IDX_W-1:0] : '0;
			ch1_end_q   <= rep1 ? index_ext[OUT_IDX_W-1:0]  : '0;
			ch2_valid_q <= rep2;
			ch2_start_q <= rep2 ? start2_ext[OUT_IDX_W-1:0] : '0;
			ch2_end_q   <= rep2 ? index_ext[OUT_IDX_W-1:0]  : '0;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {{(OUT_W - OUT_FIELD_W){1'b0}},
	                   ch2_end_q, ch2_start_q, ch2_valid_q,
	                   ch1_end_q, ch1_start_q, ch1_valid_q};

endmodule

[rtl/dtid_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtid_checker - port-level checks
// Watches the report stream of the interval detector.
// ----------------------------------------------------------------------------
module dtid_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       m_tvalid,
	input logic                       m_tready,
	input logic [dtid_pkg::OUT_W-1:0] m_tdata
);
	import dtid_pkg::*;

	localparam int CH2_LSB = 1 + 2 * OUT_IDX_W;

	// Reset leaves no report pending
	a_reset_idle: assert property (@(posedge clk) !arst_n |-> !m_tvalid)
		else $error("report valid during reset");

	// A stalled report holds its value
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("stalled report changed");

	// Every report carries at least one interval
	a_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[0] || m_tdata[CH2_LSB]))
		else $error("report without an interval");

	// A silent channel reports zero indices
	a_silent_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[0] || m_tdata[CH2_LSB-1:1] == '0) &&
		             (m_tdata[CH2_LSB] ||
		              m_tdata[CH2_LSB+2*OUT_IDX_W:CH2_LSB+1] == '0))
		else $error("silent channel has nonzero indices");

	// Both channels closing on one sample share the end index
	a_same_end: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[0] && m_tdata[CH2_LSB] |->
		m_tdata[2*OUT_IDX_W:OUT_IDX_W+1] ==
		m_tdata[CH2_LSB+2*OUT_IDX_W:CH2_LSB+OUT_IDX_W+1])
		else $error("channel end indices differ");

endmodule

bind dual_threshold_interval_detector dtid_checker u_dtid_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
